// ===== design/ctcf_pkg.sv =====
// Shared types and constants for the caption triplet cluster framer.
// No dependencies; every other design file but ctcf_ram imports this package.
package ctcf_pkg;

  // Cluster store sizing and the flush threshold.
  localparam int MAX_BLOCKS   = 32;
  localparam int STORE_DEPTH  = 32;
  localparam int BLOCK_LIMIT  = (MAX_BLOCKS < 1) ? 1 :
                                ((MAX_BLOCKS > STORE_DEPTH) ? STORE_DEPTH : MAX_BLOCKS);
  localparam int STORE_AW     = $clog2(STORE_DEPTH);
  localparam int COUNT_W      = $clog2(STORE_DEPTH + 1);

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

  // Input command codes.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_EOS  = 1'b1;

  // Result kinds.
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_BLOCK  = 1'b1;

  // Queue operation codes.
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // Caption byte tests.
  localparam logic [7:0] VALID_MASK = 8'h04;
  localparam logic [7:0] TYPE_MASK  = 8'h03;

  typedef struct packed {
    logic              command;
    logic [7:0]        data_byte;
    logic signed [63:0] packet_time;
    logic              time_valid;
    logic              last_in_packet;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic signed [63:0] header_time;
    logic [15:0]       block_count;
    logic [23:0]       block_bytes;
    logic              last;
  } result_t;

  // One queued command: a flush carries the cluster time, an append the block.
  typedef struct packed {
    logic        op;
    logic [63:0] data;
  } cmd_t;

  // Up to two commands leave the front for each accepted item.
  typedef struct packed {
    logic first_en;
    logic second_en;
    cmd_t first;
    cmd_t second;
  } push_t;

endpackage

// ===== design/ctcf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ctcf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ctcf_front.sv =====
// Front part: scans packet bytes for caption blocks and tracks the cluster.
// Depends on ctcf_pkg; emits flush and append commands to the queue.
module ctcf_front import ctcf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  take,
  input  item_t item,
  output push_t push
);

  logic [1:0]         pos, pos_next;
  logic [1:0]         phase, phase_next;
  logic               dropped, dropped_next;
  logic [7:0]         part_hi, part_hi_next;
  logic [7:0]         part_lo, part_lo_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [63:0]        ctime, ctime_next;
  logic               ctv, ctv_next;

  logic               flush_en;
  logic               append_en;
  logic [23:0]        blk;
  logic               differ;
  logic               drop_eff;
  logic [COUNT_W-1:0] cnt_a;
  logic               starts;

  localparam logic [1:0] PH_SCAN = 2'd0;
  localparam logic [1:0] PH_ONE  = 2'd1;
  localparam logic [1:0] PH_TWO  = 2'd2;

  assign blk    = {part_hi, part_lo, item.data_byte};
  assign differ = (item.time_valid != ctv) ||
                  (item.time_valid && (item.packet_time != ctime));
  assign starts = ((item.data_byte & VALID_MASK) != 8'h00) ||
                  ((item.data_byte & TYPE_MASK) == TYPE_MASK);

  always_comb begin
    pos_next     = pos;
    phase_next   = phase;
    dropped_next = dropped;
    part_hi_next = part_hi;
    part_lo_next = part_lo;
    count_next   = count;
    ctime_next   = ctime;
    ctv_next     = ctv;
    flush_en     = 1'b0;
    append_en    = 1'b0;
    cnt_a        = count;
    drop_eff     = dropped;
    if (take) begin
      if (item.command == CMD_EOS) begin
        flush_en     = (count != '0);
        count_next   = '0;
        ctime_next   = '0;
        ctv_next     = 1'b0;
        pos_next     = 2'd0;
        phase_next   = PH_SCAN;
        dropped_next = 1'b0;
      end else begin
        // The timestamp check happens on the third byte of a packet.
        if (pos == 2'd2) begin
          if (differ) begin
            flush_en   = (count != '0);
            cnt_a      = '0;
            ctv_next   = item.time_valid;
            ctime_next = item.time_valid ? item.packet_time : 64'd0;
          end
          if (!item.time_valid) begin
            drop_eff = 1'b1;
          end
        end
        pos_next = (pos == 2'd3) ? 2'd3 : pos + 2'd1;
        unique case (phase)
          PH_SCAN: begin
            if (starts) begin
              part_hi_next = item.data_byte;
              phase_next   = PH_ONE;
            end
          end
          PH_ONE: begin
            part_lo_next = item.data_byte;
            phase_next   = PH_TWO;
          end
          default: begin
            phase_next = PH_SCAN;
            if (!drop_eff) begin
              // A full store is flushed just before the next append.
              if (cnt_a >= COUNT_W'(BLOCK_LIMIT)) begin
                flush_en = 1'b1;
                cnt_a    = '0;
              end
              append_en = 1'b1;
              cnt_a     = cnt_a + COUNT_W'(1);
            end
          end
        endcase
        count_next   = cnt_a;
        dropped_next = drop_eff;
        if (item.last_in_packet) begin
          pos_next     = 2'd0;
          phase_next   = PH_SCAN;
          dropped_next = 1'b0;
        end
      end
    end
  end

  // The flushed cluster always carries the time held before this item.
  always_comb begin
    push.first_en  = flush_en | append_en;
    push.second_en = flush_en & append_en;
    push.first.op  = flush_en ? OP_FLUSH : OP_APPEND;
    push.first.data = flush_en ? ctime : {40'd0, blk};
    push.second.op   = OP_APPEND;
    push.second.data = {40'd0, blk};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= 2'd0;
      phase   <= PH_SCAN;
      dropped <= 1'b0;
      count   <= '0;
      ctime   <= '0;
      ctv     <= 1'b0;
    end else begin
      pos     <= pos_next;
      phase   <= phase_next;
      dropped <= dropped_next;
      count   <= count_next;
      ctime   <= ctime_next;
      ctv     <= ctv_next;
    end
    part_hi <= part_hi_next;
    part_lo <= part_lo_next;
  end

endmodule

// ===== design/ctcf_queue.sv =====
// Short command queue between front and back: two pushes, one pop a cycle.
// Depends on ctcf_pkg.
module ctcf_queue import ctcf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  input  logic  pop,
  output logic  room2,
  output logic  nonempty,
  output cmd_t  head
);

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr, rptr;
  logic [QUEUE_CW-1:0] count;
  logic [QUEUE_CW-1:0] pushes;

  assign room2    = (count <= QUEUE_CW'(QUEUE_DEPTH - 2));
  assign nonempty = (count != '0);
  assign head     = entries[rptr];
  assign pushes   = QUEUE_CW'(push.first_en) + QUEUE_CW'(push.second_en);

  always_ff @(posedge clk) begin
    if (push.first_en) begin
      entries[wptr] <= push.first;
    end
    if (push.second_en) begin
      entries[wptr + QUEUE_AW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QUEUE_AW'(pushes);
      rptr  <= rptr + QUEUE_AW'(pop);
      count <= count + pushes - QUEUE_CW'(pop);
    end
  end

endmodule

// ===== design/ctcf_back.sv =====
// Back part: keeps the cluster store and plays out flushed clusters.
// Depends on ctcf_pkg and ctcf_ram.
module ctcf_back import ctcf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    nonempty,
  input  cmd_t    head,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_HEAD  = 2'd1;
  localparam logic [1:0] ST_BLOCK = 2'd2;

  logic [1:0]          state, state_next;
  logic [COUNT_W-1:0]  wp, wp_next;
  logic [STORE_AW-1:0] idx, idx_next;
  logic [63:0]         ftime;
  logic                out_load;
  logic                emit;
  logic                last_blk;
  logic                we;
  logic [23:0]         rdata;
  result_t             res_next;

  assign out_load = !result_valid || !result_stall;
  assign last_blk = ((COUNT_W'(idx) + COUNT_W'(1)) == wp);
  assign pop      = (state == ST_IDLE) && nonempty;
  assign we       = pop && (head.op == OP_APPEND);

  // The read address follows the next index so rdata holds store[idx] while blocks play out.
  ctcf_ram #(.WIDTH(24), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (wp[STORE_AW-1:0]),
    .wdata (head.data[23:0]),
    .raddr (idx_next),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    wp_next    = wp;
    idx_next   = idx;
    emit       = 1'b0;
    res_next   = result;
    unique case (state)
      ST_IDLE: begin
        if (pop) begin
          if (head.op == OP_APPEND) begin
            wp_next = wp + COUNT_W'(1);
          end else begin
            state_next = ST_HEAD;
            idx_next   = '0;
          end
        end
      end
      ST_HEAD: begin
        if (out_load) begin
          emit                 = 1'b1;
          res_next.kind        = KIND_HEADER;
          res_next.header_time = ftime;
          res_next.block_count = 16'(wp);
          res_next.block_bytes = '0;
          res_next.last        = 1'b0;
          state_next           = ST_BLOCK;
        end
      end
      ST_BLOCK: begin
        if (out_load) begin
          emit                 = 1'b1;
          res_next.kind        = KIND_BLOCK;
          res_next.header_time = '0;
          res_next.block_count = '0;
          res_next.block_bytes = rdata;
          res_next.last        = last_blk;
          if (last_blk) begin
            state_next = ST_IDLE;
            wp_next    = '0;
          end else begin
            idx_next = idx + STORE_AW'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      wp           <= '0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      wp    <= wp_next;
      idx   <= idx_next;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
    if (emit) begin
      result <= res_next;
    end
    if (pop && (head.op == OP_FLUSH)) begin
      ftime <= head.data;
    end
  end

endmodule

// ===== design/caption_triplet_cluster_framer_unit.sv =====
// Top level of the caption triplet cluster framer.
// Depends on ctcf_pkg, ctcf_front, ctcf_queue and ctcf_back.
//
//   Channel  | Valid         | Stall         | Payload
//   ---------+---------------+---------------+------------------------------
//   input    | item_valid    | item_stall    | item   (item_t, one byte/cmd)
//   output   | result_valid  | result_stall  | result (result_t)
//
// Flow: one request a cycle is taken while the command queue has room for two
// commands; item_stall rises once more than two commands wait. An append costs
// the back a single pop that writes the store; a flush pops, emits the header,
// then emits its blocks in order, each held while result_stall is high.
// Reset (rst, synchronous) clears the queue, scan and cluster state; no store entry
// is played out before it is written. result_stall holds the output register.
module caption_triplet_cluster_framer_unit import ctcf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  push_t push;
  cmd_t  head;
  logic  room2;
  logic  nonempty;
  logic  pop;
  logic  take;

  // A request is taken only when both commands it may cause fit in the queue.
  // item_stall never depends on item_valid.
  assign item_stall = !room2;
  assign take       = item_valid && room2;

  // The front scans bytes, checks timestamps and decides flushes and appends.
  ctcf_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (item),
    .push (push)
  );

  // The queue decouples the front from the back's multi-cycle flushes.
  ctcf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (pop),
    .room2    (room2),
    .nonempty (nonempty),
    .head     (head)
  );

  // The back owns the cluster store and drives the result register.
  ctcf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .nonempty     (nonempty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== bench/caption_triplet_cluster_framer_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for caption_triplet_cluster_framer_unit: drives caption packet bytes,
// predicts the framed cluster stream and checks every result in order.
// Depends on ctcf_pkg and the framer RTL.
module caption_triplet_cluster_framer_unit_tb;
  import ctcf_pkg::*;

  // Upper bound on the run in clock cycles, far above the slowest correct run.
  localparam int CYCLE_LIMIT = 200000;
  // Random requests after the directed part.
  localparam int RANDOM_REQUESTS = 300;

  logic    clk;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  caption_triplet_cluster_framer_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Requests waiting to be driven, and the framed results still owed by the block.
  item_t   byte_requests[$];
  result_t awaited_frames[$];
  // Results produced by the request that is being predicted right now.
  result_t batch[$];

  int unsigned total_requests = 0;
  int unsigned accepted_requests = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Predictor state: the open cluster and the scan of the current packet.
  logic [23:0] blk_store [0:STORE_DEPTH-1];
  int          blk_count = 0;
  logic [63:0] clu_time = '0;
  logic        clu_has_time = 1'b0;
  int          pkt_pos = 0;       // bytes seen in this packet, saturating at 3
  int          scan_phase = 0;    // 0 scanning, 1 or 2 bytes of a block held
  logic [15:0] held_bytes = '0;
  logic        pkt_ignored = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The run has three idling phases by progress through the requests: sender
  // idles lightly while the receiver stalls heavily, then the reverse, then
  // neither side idles at all.
  function automatic int idle_pct(input bit sender);
    int phase;
    phase = (total_requests == 0) ? 2 : (accepted_requests * 3) / total_requests;
    if (phase == 0) return sender ? 21 : 52;
    if (phase == 1) return sender ? 52 : 21;
    return 0;
  endfunction

  // Emits the open cluster as a header followed by its blocks. An empty
  // cluster emits nothing.
  task automatic emit_cluster();
    result_t r;
    if (blk_count == 0) return;
    r = '0;
    r.kind        = KIND_HEADER;
    r.header_time = clu_time;
    r.block_count = 16'(blk_count);
    batch.push_back(r);
    for (int i = 0; i < blk_count; i++) begin
      r = '0;
      r.kind        = KIND_BLOCK;
      r.block_bytes = blk_store[i];
      batch.push_back(r);
    end
    blk_count = 0;
  endtask

  task automatic restart_packet();
    pkt_pos     = 0;
    scan_phase  = 0;
    held_bytes  = '0;
    pkt_ignored = 1'b0;
  endtask

  // Predicts the results of one accepted request and appends them to the
  // queue of awaited frames, with the last flag on the final one.
  task automatic frame_caption_byte(input item_t it);
    logic        differ;
    logic [23:0] blk;
    result_t     r;
    batch.delete();
    if (it.command == CMD_EOS) begin
      // End of stream flushes, forgets the timestamp and drops any packet.
      emit_cluster();
      clu_time     = '0;
      clu_has_time = 1'b0;
      restart_packet();
    end else begin
      // The timestamp is judged on the third byte only, so a packet shorter
      // than three bytes never touches the cluster.
      if (pkt_pos == 2) begin
        differ = (it.time_valid != clu_has_time) ||
                 (it.time_valid && (it.packet_time != clu_time));
        if (differ) begin
          emit_cluster();
          clu_has_time = it.time_valid;
          clu_time     = it.time_valid ? it.packet_time : '0;
        end
        if (!it.time_valid) pkt_ignored = 1'b1;
      end
      if (pkt_pos < 3) pkt_pos++;

      case (scan_phase)
        0: begin
          // A block starts on the valid bit or on caption type 3.
          if (((it.data_byte & VALID_MASK) != 0) ||
              ((it.data_byte & TYPE_MASK) == TYPE_MASK)) begin
            held_bytes = {it.data_byte, 8'h00};
            scan_phase = 1;
          end
        end
        1: begin
          held_bytes[7:0] = it.data_byte;
          scan_phase      = 2;
        end
        default: begin
          blk        = {held_bytes, it.data_byte};
          scan_phase = 0;
          if (!pkt_ignored) begin
            // A full store is flushed only when another block must go in;
            // the cluster keeps its timestamp.
            if (blk_count >= BLOCK_LIMIT) emit_cluster();
            blk_store[blk_count] = blk;
            blk_count++;
          end
        end
      endcase

      // A block still incomplete at the end of the packet is lost here.
      if (it.last_in_packet) restart_packet();
    end
    for (int i = 0; i < batch.size(); i++) begin
      r      = batch[i];
      r.last = (i == batch.size() - 1);
      awaited_frames.push_back(r);
    end
  endtask

  // Driver: a new request is presented only when the current one has been
  // taken or none is up, so a stalled payload never changes.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        frame_caption_byte(item);
        accepted_requests++;
      end
      if (!item_valid || !item_stall) begin
        if (byte_requests.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          item       <= byte_requests.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back pressure, and every accepted result is checked
  // field by field against the oldest awaited frame.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(99) < idle_pct(1'b0));
      if (result_valid && !result_stall) begin
        if (awaited_frames.size() == 0) begin
          $error("result with nothing awaited: kind %0d", result.kind);
          error_count++;
        end else begin
          want = awaited_frames.pop_front();
          if (result.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, result.kind);
            error_count++;
          end
          if (result.header_time !== want.header_time) begin
            $error("header_time: expected %0d, got %0d", want.header_time,
                   result.header_time);
            error_count++;
          end
          if (result.block_count !== want.block_count) begin
            $error("block_count: expected %0d, got %0d", want.block_count,
                   result.block_count);
            error_count++;
          end
          if (result.block_bytes !== want.block_bytes) begin
            $error("block_bytes: expected %06h, got %06h", want.block_bytes,
                   result.block_bytes);
            error_count++;
          end
          if (result.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, result.last);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic add_req(input logic cmd, input logic [7:0] b, input logic [63:0] t,
                         input logic tv, input logic lst);
    item_t it;
    it.command        = cmd;
    it.data_byte      = b;
    it.packet_time    = t;
    it.time_valid     = tv;
    it.last_in_packet = lst;
    byte_requests.push_back(it);
  endtask

  // Random timestamp, now and then one of the extremes.
  function automatic logic [63:0] pick_time();
    case ($urandom_range(15))
      0: return 64'h7FFF_FFFF_FFFF_FFFF;
      1: return 64'h8000_0000_0000_0000;
      2: return 64'h0;
      3: return 64'hFFFF_FFFF_FFFF_FFFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One packet whose triplets mostly open with a block start byte, so that
  // the scan stays aligned and blocks get kept.
  task automatic add_packet(input logic [63:0] t, input logic tv, input int nbytes,
                            input int start_pct);
    logic [7:0] b;
    for (int j = 0; j < nbytes; j++) begin
      b = 8'($urandom);
      if ((j % 3 == 0) && ($urandom_range(99) < start_pct)) b = b | VALID_MASK;
      add_req(CMD_BYTE, b, t, tv, j == nbytes - 1);
    end
  endtask

  initial begin
    logic [63:0] t;
    int          directed_count;
    int          cluster_idx;
    int          pick;
    int          npk;
    int          nb;

    // Directed part. A block kept through the valid bit, at the largest time.
    add_req(CMD_BYTE, 8'h04, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    add_req(CMD_BYTE, 8'hAA, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    add_req(CMD_BYTE, 8'h55, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
    // New smallest time flushes; a type-3 block, a skipped byte and a
    // trailing block cut short by the end of the packet.
    add_req(CMD_BYTE, 8'h03, 64'h8000_0000_0000_0000, 1'b1, 1'b0);
    add_req(CMD_BYTE, 8'hFF, 64'h8000_0000_0000_0000, 1'b1, 1'b0);
    add_req(CMD_BYTE, 8'h00, 64'h8000_0000_0000_0000, 1'b1, 1'b0);
    add_req(CMD_BYTE, 8'h00, 64'h8000_0000_0000_0000, 1'b1, 1'b0);
    add_req(CMD_BYTE, 8'h07, 64'h8000_0000_0000_0000, 1'b1, 1'b0);
    add_req(CMD_BYTE, 8'h12, 64'h8000_0000_0000_0000, 1'b1, 1'b1);
    // A two-byte packet with another time has no effect.
    add_req(CMD_BYTE, 8'hFF, 64'h1234_5678_9ABC_DEF0, 1'b1, 1'b0);
    add_req(CMD_BYTE, 8'hFF, 64'h1234_5678_9ABC_DEF0, 1'b1, 1'b1);
    // A packet without a timestamp flushes the cluster and is ignored.
    add_req(CMD_BYTE, 8'hF8, 64'h0, 1'b0, 1'b0);
    add_req(CMD_BYTE, 8'h07, 64'h0, 1'b0, 1'b0);
    add_req(CMD_BYTE, 8'h01, 64'h0, 1'b0, 1'b1);
    // Time zero with a timestamp still differs from having none.
    add_req(CMD_BYTE, 8'hFC, 64'h0, 1'b1, 1'b0);
    add_req(CMD_BYTE, 8'h01, 64'h0, 1'b1, 1'b0);
    add_req(CMD_BYTE, 8'h02, 64'h0, 1'b1, 1'b1);
    // End of stream in the middle of a packet.
    add_req(CMD_BYTE, 8'h07, 64'h0, 1'b1, 1'b0);
    add_req(CMD_EOS, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
    // End of stream with an empty cluster emits nothing.
    add_req(CMD_EOS, 8'h00, 64'h0, 1'b0, 1'b0);
    // The time of the third byte is the one that counts.
    add_req(CMD_BYTE, 8'h05, 64'h5555_5555_5555_5555, 1'b1, 1'b0);
    add_req(CMD_BYTE, 8'h80, 64'h5555_5555_5555_5555, 1'b0, 1'b0);
    add_req(CMD_BYTE, 8'h40, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
    add_req(CMD_EOS, 8'h00, 64'h0, 1'b0, 1'b0);
    directed_count = byte_requests.size();

    // Random part: mostly clusters of well-formed packets sharing a time,
    // with short packets, untimed packets, end of stream and noise mixed in.
    // The second cluster is long enough to overflow the store.
    cluster_idx = 0;
    while (byte_requests.size() < directed_count + RANDOM_REQUESTS) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        t   = pick_time();
        npk = (cluster_idx == 1) ? 12 : $urandom_range(1, 4);
        for (int p = 0; p < npk; p++) begin
          nb = (cluster_idx == 1) ? 9 : 3 * $urandom_range(1, 4);
          if ($urandom_range(9) == 0) nb = nb + $urandom_range(1, 2);
          add_packet(t, 1'b1, nb, (cluster_idx == 1) ? 100 : 85);
        end
        cluster_idx++;
      end else if (pick < 80) begin
        add_packet(pick_time(), 1'($urandom), $urandom_range(1, 2), 50);
      end else if (pick < 88) begin
        add_packet(pick_time(), 1'b0, $urandom_range(3, 9), 85);
      end else if (pick < 94) begin
        add_req(CMD_EOS, 8'($urandom), {$urandom, $urandom}, 1'($urandom), 1'($urandom));
      end else begin
        // Broken packet: random bytes, a new time on every byte, and the end
        // mark set at random.
        nb = $urandom_range(1, 10);
        for (int j = 0; j < nb; j++)
          add_req(CMD_BYTE, 8'($urandom), pick_time(), 1'($urandom), 1'($urandom));
      end
    end
    add_req(CMD_EOS, 8'h00, 64'h0, 1'b0, 1'b0);
    total_requests = byte_requests.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (byte_requests.size() != 0 || item_valid) @(posedge clk);
    while (awaited_frames.size() != 0) @(posedge clk);
    // Room for a stray late result to show up and be caught.
    repeat (80) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== caption_triplet_cluster_framer_unit.f =====
design/ctcf_pkg.sv
design/ctcf_ram.sv
design/ctcf_front.sv
design/ctcf_queue.sv
design/ctcf_back.sv
design/caption_triplet_cluster_framer_unit.sv
bench/caption_triplet_cluster_framer_unit_tb.sv
